### rtl/core/mtpwm_pkg.sv
package mtpwm_pkg;

	// block sizing
	localparam int TIMER_COUNT        = 3;
	localparam int CHANNELS_PER_TIMER = 4;
	localparam int COUNTER_BITS       = 16;

	localparam int SIGNAL_TOTAL = TIMER_COUNT * CHANNELS_PER_TIMER;
	localparam int CHAN_BITS    = (CHANNELS_PER_TIMER > 1) ? $clog2(CHANNELS_PER_TIMER) : 1;

	// fixed field widths
	localparam int PRESCALE_W  = 16;
	localparam int CFG_DATA_W  = 16;
	localparam int CFG_INDEX_W = 3;
	localparam int SIGNAL_W    = 4;
	localparam int VALUE_W     = 16;
	localparam int LEVELS_W    = 12;
	localparam int WRAPS_W     = 3;

	// internal vectors wide enough for both the signal count and the port
	localparam int LEVEL_VEC_W = (SIGNAL_TOTAL > LEVELS_W) ? SIGNAL_TOTAL : LEVELS_W;
	localparam int WRAP_VEC_W  = (TIMER_COUNT > WRAPS_W) ? TIMER_COUNT : WRAPS_W;

	// register map
	localparam int REG_PER_KIND = 3;
	localparam logic [CFG_INDEX_W-1:0] CFG_PRESCALE0 = 3'd0;
	localparam logic [CFG_INDEX_W-1:0] CFG_PERIOD0   = 3'd3;
	localparam logic [CFG_INDEX_W-1:0] CFG_ENABLE    = 3'd6;

	localparam logic [PRESCALE_W-1:0]   PRESCALE_RESET = '0;
	localparam logic [COUNTER_BITS-1:0] PERIOD_RESET   = COUNTER_BITS'(16'hFFFF);

	// input function codes
	localparam logic FUNC_TICK    = 1'b0;
	localparam logic FUNC_COMPARE = 1'b1;

	typedef struct packed {
		logic [TIMER_COUNT-1:0][PRESCALE_W-1:0]   prescale;
		logic [TIMER_COUNT-1:0][COUNTER_BITS-1:0] period;
		logic [LEVELS_W-1:0]                      enable;
	} cfg_t;

	typedef struct packed {
		logic                    tick;
		logic                    wr_en;
		logic [CHAN_BITS-1:0]    wr_chan;
		logic [COUNTER_BITS-1:0] wr_value;
	} timer_ctrl_t;

endpackage

### rtl/core/mtpwm_cfg_regs.sv
module mtpwm_cfg_regs (
	input  logic                                   clk,
	input  logic                                   arst_n,
	input  logic                                   wr_en,
	input  logic [mtpwm_pkg::CFG_INDEX_W-1:0]      wr_index,
	input  logic [mtpwm_pkg::CFG_DATA_W-1:0]       wr_data,
	output mtpwm_pkg::cfg_t                        cfg
);

	mtpwm_pkg::cfg_t cfg_q;

	for (genvar t = 0; t < mtpwm_pkg::TIMER_COUNT; t++) begin : g_timer
		if (t < mtpwm_pkg::REG_PER_KIND) begin : g_mapped
			always_ff @(posedge clk or negedge arst_n) begin
				if (!arst_n) begin
					cfg_q.prescale[t] <= mtpwm_pkg::PRESCALE_RESET;
					cfg_q.period[t]   <= mtpwm_pkg::PERIOD_RESET;
				end else if (wr_en) begin
					if (wr_index == mtpwm_pkg::CFG_INDEX_W'(mtpwm_pkg::CFG_PRESCALE0 + t))
						cfg_q.prescale[t] <= wr_data[mtpwm_pkg::PRESCALE_W-1:0];
					if (wr_index == mtpwm_pkg::CFG_INDEX_W'(mtpwm_pkg::CFG_PERIOD0 + t))
						cfg_q.period[t] <= mtpwm_pkg::COUNTER_BITS'(wr_data[15:0]);
				end
			end
		end else begin : g_fixed
			// timers past the register map keep their reset settings
			assign cfg_q.prescale[t] = mtpwm_pkg::PRESCALE_RESET;
			assign cfg_q.period[t]   = mtpwm_pkg::PERIOD_RESET;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q.enable <= '0;
		end else if (wr_en && wr_index == mtpwm_pkg::CFG_ENABLE) begin
			cfg_q.enable <= wr_data[mtpwm_pkg::LEVELS_W-1:0];
		end
	end

	assign cfg = cfg_q;

endmodule

### rtl/core/mtpwm_timer.sv
module mtpwm_timer (
	input  logic                                         clk,
	input  logic                                         arst_n,
	input  mtpwm_pkg::timer_ctrl_t                       ctrl,
	input  logic [mtpwm_pkg::PRESCALE_W-1:0]             prescale,
	input  logic [mtpwm_pkg::COUNTER_BITS-1:0]           period,
	input  logic [mtpwm_pkg::CHANNELS_PER_TIMER-1:0]     enable,
	output logic [mtpwm_pkg::CHANNELS_PER_TIMER-1:0]     levels,
	output logic                                         wrap
);

	localparam int CH = mtpwm_pkg::CHANNELS_PER_TIMER;
	localparam int CB = mtpwm_pkg::COUNTER_BITS;

	logic [mtpwm_pkg::PRESCALE_W-1:0] presc_q, presc_nxt;
	logic [CB-1:0]                    count_q, count_nxt;
	logic [CH-1:0][CB-1:0]            preload_q;
	logic [CH-1:0][CB-1:0]            active_q, active_nxt;
	logic                             presc_hit;
	logic                             count_hit;

	// at or above the limit counts as reaching it
	assign presc_hit = (presc_q >= prescale);
	assign count_hit = (count_q >= period);
	assign wrap      = ctrl.tick && presc_hit && count_hit;

	always_comb begin
		presc_nxt = presc_q;
		count_nxt = count_q;
		if (ctrl.tick) begin
			if (presc_hit) begin
				presc_nxt = '0;
				count_nxt = count_hit ? '0 : count_q + CB'(1);
			end else begin
				presc_nxt = presc_q + mtpwm_pkg::PRESCALE_W'(1);
			end
		end
	end

	for (genvar c = 0; c < CH; c++) begin : g_chan
		assign active_nxt[c] = wrap ? preload_q[c] : active_q[c];
		assign levels[c]     = enable[c] && (count_nxt < active_nxt[c]);

		always_ff @(posedge clk or negedge arst_n) begin
			if (!arst_n) begin
				preload_q[c] <= '0;
			end else if (ctrl.wr_en && ctrl.wr_chan == mtpwm_pkg::CHAN_BITS'(c)) begin
				preload_q[c] <= ctrl.wr_value;
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			presc_q  <= '0;
			count_q  <= '0;
			active_q <= '0;
		end else begin
			presc_q  <= presc_nxt;
			count_q  <= count_nxt;
			active_q <= active_nxt;
		end
	end

endmodule

### rtl/core/multi_timer_pwm_generator.sv
// three prescaled pwm timers with four channels each, twelve pwm levels out
//
// input channel (in_valid / in_stall): one transaction is either a tick
// (func = 0) that advances every timer, or a compare write (func = 1) that
// loads the preload compare of one signal; it goes active at the next wrap
// output channel (out_valid / out_stall): one transaction per input, carrying
// the levels of all signals after that input and the timers that wrapped
// configuration channel (cfg_valid / cfg_ready): always ready, index 0..2
// prescale, 3..5 period, 6 output enable mask; other indexes are dropped
// path: an input transaction passes the input register, then the timer update
// and level compare into the result register
// throughput: one transaction per cycle while the output is not stalled
// reset: counters, compares and config go to their reset values, no result
// is pending; output is low while disabled
// stall: a held result keeps its value; one more input is taken into the
// input register, then in_stall rises until the result is taken
module multi_timer_pwm_generator (
	input  logic                                   clk,
	input  logic                                   arst_n,

	input  logic                                   in_valid,
	output logic                                   in_stall,
	input  logic                                   func,
	input  logic [mtpwm_pkg::SIGNAL_W-1:0]         signal,
	input  logic [mtpwm_pkg::VALUE_W-1:0]          compare_value,

	output logic                                   out_valid,
	input  logic                                   out_stall,
	output logic [mtpwm_pkg::LEVELS_W-1:0]         pwm_levels,
	output logic [mtpwm_pkg::WRAPS_W-1:0]          wrap_flags,

	input  logic                                   cfg_valid,
	output logic                                   cfg_ready,
	input  logic [mtpwm_pkg::CFG_INDEX_W-1:0]      cfg_index,
	input  logic [mtpwm_pkg::CFG_DATA_W-1:0]       cfg_data
);

	localparam int CH = mtpwm_pkg::CHANNELS_PER_TIMER;

	// input register
	logic                              valid_s1;
	logic                              func_s1;
	logic [mtpwm_pkg::SIGNAL_W-1:0]    signal_s1;
	logic [mtpwm_pkg::VALUE_W-1:0]     value_s1;

	// result register
	logic                              out_valid_q;
	logic [mtpwm_pkg::LEVELS_W-1:0]    levels_q;
	logic [mtpwm_pkg::WRAPS_W-1:0]     wraps_q;

	logic                              advance;
	mtpwm_pkg::cfg_t                   cfg;

	logic [mtpwm_pkg::SIGNAL_TOTAL-1:0] levels_sig;
	logic [mtpwm_pkg::TIMER_COUNT-1:0]  wrap_sig;
	logic [mtpwm_pkg::LEVEL_VEC_W-1:0]  levels_wide;
	logic [mtpwm_pkg::LEVEL_VEC_W-1:0]  enable_wide;
	logic [mtpwm_pkg::WRAP_VEC_W-1:0]   wrap_wide;

	// the item in the input register moves on whenever the result slot frees
	assign advance  = valid_s1 && (!out_valid_q || !out_stall);
	assign in_stall = valid_s1 && !advance;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (!in_stall) begin
			valid_s1 <= in_valid;
		end
	end

	always_ff @(posedge clk) begin
		if (in_valid && !in_stall) begin
			func_s1   <= func;
			signal_s1 <= signal;
			value_s1  <= compare_value;
		end
	end

	// configuration registers
	assign cfg_ready = 1'b1;

	mtpwm_cfg_regs u_cfg (
		.clk      (clk),
		.arst_n   (arst_n),
		.wr_en    (cfg_valid && cfg_ready),
		.wr_index (cfg_index),
		.wr_data  (cfg_data),
		.cfg      (cfg)
	);

	// disabled signals past the mask width read as off
	assign enable_wide = mtpwm_pkg::LEVEL_VEC_W'(cfg.enable);

	for (genvar t = 0; t < mtpwm_pkg::TIMER_COUNT; t++) begin : g_timer
		mtpwm_pkg::timer_ctrl_t ctrl;
		logic                   hit;

		// compare write lands in this timer when the signal falls in its range
		assign hit = (32'(signal_s1) >= 32'(t * CH)) && (32'(signal_s1) < 32'((t + 1) * CH));

		assign ctrl.tick     = advance && (func_s1 == mtpwm_pkg::FUNC_TICK);
		assign ctrl.wr_en    = advance && (func_s1 == mtpwm_pkg::FUNC_COMPARE) && hit;
		assign ctrl.wr_chan  = mtpwm_pkg::CHAN_BITS'(32'(signal_s1) - 32'(t * CH));
		assign ctrl.wr_value = mtpwm_pkg::COUNTER_BITS'(value_s1);

		mtpwm_timer u_timer (
			.clk      (clk),
			.arst_n   (arst_n),
			.ctrl     (ctrl),
			.prescale (cfg.prescale[t]),
			.period   (cfg.period[t]),
			.enable   (enable_wide[t*CH +: CH]),
			.levels   (levels_sig[t*CH +: CH]),
			.wrap     (wrap_sig[t])
		);
	end

	assign levels_wide = mtpwm_pkg::LEVEL_VEC_W'(levels_sig);
	assign wrap_wide   = mtpwm_pkg::WRAP_VEC_W'(wrap_sig);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (advance) begin
			out_valid_q <= 1'b1;
		end else if (!out_stall) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (advance) begin
			levels_q <= levels_wide[mtpwm_pkg::LEVELS_W-1:0];
			wraps_q  <= wrap_wide[mtpwm_pkg::WRAPS_W-1:0];
		end
	end

	assign out_valid  = out_valid_q;
	assign pwm_levels = levels_q;
	assign wrap_flags = wraps_q;

	// a compare write never reports a wrap
	a_write_no_wrap: assert property (@(posedge clk) disable iff (!arst_n)
		(advance && func_s1 == mtpwm_pkg::FUNC_COMPARE) |=> (wrap_flags == '0))
		else $error("wrap reported on a compare write");

	// input is held back only by a full result slot under stall
	a_stall_cause: assert property (@(posedge clk) disable iff (!arst_n)
		in_stall |-> (valid_s1 && out_valid_q && out_stall))
		else $error("input stalled without a blocked result");

	// every item that moves on produces a result
	a_advance_result: assert property (@(posedge clk) disable iff (!arst_n)
		advance |=> out_valid)
		else $error("result missing after advance");

	// a taken result with nothing behind it leaves the output empty
	a_drain: assert property (@(posedge clk) disable iff (!arst_n)
		(out_valid && !out_stall && !valid_s1) |=> !out_valid)
		else $error("result repeated");

endmodule
